/* hw/rtl/rcp_pkg.sv */
`timescale 1ns / 1ps

package rcp_pkg;

	localparam int MAX_RESIDUES = 1024;
	localparam int IDX_W = $clog2(MAX_RESIDUES);
	localparam int CNT_W = IDX_W + 1;

	localparam int COORD_W = 25;
	localparam int CODE_W = 5;
	localparam int OP_W = 2;
	localparam int LIMIT_W = 48;
	localparam int MINSEP_W = 11;
	localparam int OUT_IDX_W = 10;
	localparam int DIST_W = 49;
	localparam int SQ_W = 2 * (COORD_W + 1);
	localparam int TOTAL_W = 19;
	localparam int GAP_SUM_W = 28;
	localparam int GAP_CMP_W = (CNT_W > MINSEP_W) ? CNT_W : MINSEP_W;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_MINSEP = 1'b1;

	localparam logic [CODE_W-1:0] GLYCINE_CODE = 5'd5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 48'd256000000;
	localparam logic [MINSEP_W-1:0] MINSEP_RESET = 11'd5;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [GAP_SUM_W-1:0] GAP_SUM_MAX = {GAP_SUM_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CNT_W:0] cntx_t;
	typedef logic [GAP_CMP_W-1:0] gap_cmp_t;
	typedef logic [SQ_W-1:0] sq_t;
	typedef logic [GAP_SUM_W:0] gap_sumx_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic valid;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/residue_contact_pair_finder.sv */
`timescale 1ns / 1ps
// Load, restart and unused operations keep the block idle for the next item. Fetch reads
// each row from the shared single-port memory in S_ROW (held while a result waits) and
// S_ROWD; a pair takes S_STEP alone if the gap or row atom rules it out, adds S_PAIR if
// the later atom is missing, and S_PAIR, S_SUM for the distance test; a new row reruns
// S_ROW. Reset empties the table, clears the scan and totals, restores both registers.

module residue_contact_pair_finder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [rcp_pkg::LIMIT_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rcp_pkg::OP_W-1:0]            operation,
	input  logic [rcp_pkg::CODE_W-1:0]          residue_code,
	input  logic signed [rcp_pkg::COORD_W-1:0]  alpha_x,
	input  logic signed [rcp_pkg::COORD_W-1:0]  alpha_y,
	input  logic signed [rcp_pkg::COORD_W-1:0]  alpha_z,
	input  logic                                alpha_present,
	input  logic signed [rcp_pkg::COORD_W-1:0]  beta_x,
	input  logic signed [rcp_pkg::COORD_W-1:0]  beta_y,
	input  logic signed [rcp_pkg::COORD_W-1:0]  beta_z,
	input  logic                                beta_present,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                contact_found,
	output logic [rcp_pkg::OUT_IDX_W-1:0]       first_index,
	output logic [rcp_pkg::OUT_IDX_W-1:0]       second_index,
	output logic [rcp_pkg::CODE_W-1:0]          first_code,
	output logic [rcp_pkg::CODE_W-1:0]          second_code,
	output logic [rcp_pkg::DIST_W-1:0]          dist_sq,
	output logic [rcp_pkg::TOTAL_W-1:0]         contact_count,
	output logic [rcp_pkg::GAP_SUM_W-1:0]       separation_sum
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROW  = 3'd1;
	localparam logic [2:0] S_ROWD = 3'd2;
	localparam logic [2:0] S_STEP = 3'd3;
	localparam logic [2:0] S_PAIR = 3'd4;
	localparam logic [2:0] S_SUM  = 3'd5;

	function automatic rcp_pkg::sq_t sq_diff(
		input logic signed [rcp_pkg::COORD_W-1:0] a,
		input logic signed [rcp_pkg::COORD_W-1:0] b
	);
		logic [rcp_pkg::COORD_W:0] d;
		logic [rcp_pkg::COORD_W:0] m;
		d = {a[rcp_pkg::COORD_W-1], a} - {b[rcp_pkg::COORD_W-1], b};
		m = d[rcp_pkg::COORD_W] ? (~d + 1'b1) : d;
		return rcp_pkg::sq_t'(m) * rcp_pkg::sq_t'(m);
	endfunction

	logic [2:0] state_q;
	rcp_pkg::cnt_t count_q;
	rcp_pkg::idx_t first_q;
	rcp_pkg::cnt_t second_q;
	logic [rcp_pkg::TOTAL_W-1:0] found_q;
	logic [rcp_pkg::GAP_SUM_W-1:0] gap_total_q;
	logic [rcp_pkg::LIMIT_W-1:0] limit_q;
	logic [rcp_pkg::MINSEP_W-1:0] minsep_q;
	logic out_valid_q;

	rcp_pkg::entry_t row_q;
	rcp_pkg::idx_t j_s1;
	rcp_pkg::cnt_t gap_s1;
	rcp_pkg::sq_t sq_x_s2;
	rcp_pkg::sq_t sq_y_s2;
	rcp_pkg::sq_t sq_z_s2;
	logic [rcp_pkg::CODE_W-1:0] code_j_s2;

	logic contact_found_q;
	logic [rcp_pkg::OUT_IDX_W-1:0] first_index_q;
	logic [rcp_pkg::OUT_IDX_W-1:0] second_index_q;
	logic [rcp_pkg::CODE_W-1:0] first_code_q;
	logic [rcp_pkg::CODE_W-1:0] second_code_q;
	logic [rcp_pkg::DIST_W-1:0] dist_sq_q;
	logic [rcp_pkg::TOTAL_W-1:0] contact_count_q;
	logic [rcp_pkg::GAP_SUM_W-1:0] separation_sum_q;

	logic in_xfer;
	logic is_gly;
	logic table_full;
	logic ram_we;
	rcp_pkg::idx_t ram_addr;
	rcp_pkg::entry_t wr_entry;
	rcp_pkg::entry_t rd_entry;
	logic [rcp_pkg::ENTRY_W-1:0] ram_rdata;
	logic row_end;
	logic row_adv;
	rcp_pkg::cnt_t gap;
	logic skip;
	rcp_pkg::sq_t d_sum;
	logic hit;
	logic emit_end;
	logic emit_hit;
	rcp_pkg::gap_sumx_t gap_sum;

	rcp_ram #(
		.WIDTH (rcp_pkg::ENTRY_W),
		.DEPTH (rcp_pkg::MAX_RESIDUES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wr_entry),
		.rdata (ram_rdata)
	);

	always_comb begin
		in_stall = (state_q != S_IDLE);
		in_xfer = in_valid && !in_stall;
		is_gly = (residue_code == rcp_pkg::GLYCINE_CODE);
		table_full = (count_q == rcp_pkg::cnt_t'(rcp_pkg::MAX_RESIDUES));
		ram_we = in_xfer && (operation == rcp_pkg::OP_LOAD) && !table_full;

		wr_entry.code = residue_code;
		wr_entry.valid = is_gly ? alpha_present : beta_present;
		wr_entry.x = is_gly ? alpha_x : beta_x;
		wr_entry.y = is_gly ? alpha_y : beta_y;
		wr_entry.z = is_gly ? alpha_z : beta_z;
		rd_entry = rcp_pkg::entry_t'(ram_rdata);

		unique case (state_q)
			S_IDLE:  ram_addr = count_q[rcp_pkg::IDX_W-1:0];
			S_ROW:   ram_addr = first_q;
			default: ram_addr = second_q[rcp_pkg::IDX_W-1:0];
		endcase

		row_end = (second_q >= count_q);
		row_adv = ((rcp_pkg::cntx_t'(first_q) + rcp_pkg::cntx_t'(2))
			< rcp_pkg::cntx_t'(count_q));
		gap = second_q - rcp_pkg::cnt_t'(first_q);
		skip = (rcp_pkg::gap_cmp_t'(gap) < rcp_pkg::gap_cmp_t'(minsep_q)) || !row_q.valid;

		d_sum = sq_x_s2 + sq_y_s2 + sq_z_s2;
		hit = (d_sum <= rcp_pkg::sq_t'(limit_q));
		emit_end = (state_q == S_STEP) && row_end && !row_adv;
		emit_hit = (state_q == S_SUM) && hit;
		gap_sum = rcp_pkg::gap_sumx_t'(gap_total_q) + rcp_pkg::gap_sumx_t'(gap_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			first_q <= '0;
			second_q <= rcp_pkg::cnt_t'(1);
			found_q <= '0;
			gap_total_q <= '0;
			limit_q <= rcp_pkg::LIMIT_RESET;
			minsep_q <= rcp_pkg::MINSEP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rcp_pkg::REG_LIMIT:  limit_q <= cfg_data;
					rcp_pkg::REG_MINSEP: minsep_q <= cfg_data[rcp_pkg::MINSEP_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (operation)
							rcp_pkg::OP_LOAD: begin
								if (!table_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							rcp_pkg::OP_FETCH: state_q <= S_ROW;
							rcp_pkg::OP_RESTART: begin
								count_q <= '0;
								first_q <= '0;
								second_q <= rcp_pkg::cnt_t'(1);
								found_q <= '0;
								gap_total_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_ROW: begin
					if (!out_valid_q) begin
						state_q <= S_ROWD;
					end
				end
				S_ROWD: state_q <= S_STEP;
				S_STEP: begin
					if (row_end) begin
						if (row_adv) begin
							first_q <= first_q + 1'b1;
							second_q <= rcp_pkg::cnt_t'(first_q) + rcp_pkg::cnt_t'(2);
							state_q <= S_ROW;
						end else begin
							out_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						second_q <= second_q + 1'b1;
						if (!skip) begin
							state_q <= S_PAIR;
						end
					end
				end
				S_PAIR: state_q <= rd_entry.valid ? S_SUM : S_STEP;
				S_SUM: begin
					if (hit) begin
						if (found_q != rcp_pkg::TOTAL_MAX) begin
							found_q <= found_q + 1'b1;
						end
						gap_total_q <= (gap_sum > rcp_pkg::gap_sumx_t'(rcp_pkg::GAP_SUM_MAX))
							? rcp_pkg::GAP_SUM_MAX : gap_sum[rcp_pkg::GAP_SUM_W-1:0];
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_STEP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROWD) begin
			row_q <= rd_entry;
		end
		if ((state_q == S_STEP) && !row_end && !skip) begin
			j_s1 <= second_q[rcp_pkg::IDX_W-1:0];
			gap_s1 <= gap;
		end
		if (state_q == S_PAIR) begin
			sq_x_s2 <= sq_diff(row_q.x, rd_entry.x);
			sq_y_s2 <= sq_diff(row_q.y, rd_entry.y);
			sq_z_s2 <= sq_diff(row_q.z, rd_entry.z);
			code_j_s2 <= rd_entry.code;
		end
		if (emit_end) begin
			contact_found_q <= 1'b0;
			first_index_q <= '0;
			second_index_q <= '0;
			first_code_q <= '0;
			second_code_q <= '0;
			dist_sq_q <= '0;
			contact_count_q <= found_q;
			separation_sum_q <= gap_total_q;
		end else if (emit_hit) begin
			contact_found_q <= 1'b1;
			first_index_q <= rcp_pkg::OUT_IDX_W'(first_q);
			second_index_q <= rcp_pkg::OUT_IDX_W'(j_s1);
			first_code_q <= row_q.code;
			second_code_q <= code_j_s2;
			dist_sq_q <= (d_sum > rcp_pkg::sq_t'(rcp_pkg::DIST_MAX))
				? rcp_pkg::DIST_MAX : d_sum[rcp_pkg::DIST_W-1:0];
			contact_count_q <= '0;
			separation_sum_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign contact_found = contact_found_q;
	assign first_index = first_index_q;
	assign second_index = second_index_q;
	assign first_code = first_code_q;
	assign second_code = second_code_q;
	assign dist_sq = dist_sq_q;
	assign contact_count = contact_count_q;
	assign separation_sum = separation_sum_q;

endmodule

/* hw/rtl/rcp_ram.sv */
`timescale 1ns / 1ps

module rcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* hw/rtl/rcp_checker.sv */
`timescale 1ns / 1ps

module rcp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [rcp_pkg::OP_W-1:0]           operation,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               contact_found,
	input logic [rcp_pkg::OUT_IDX_W-1:0]      first_index,
	input logic [rcp_pkg::OUT_IDX_W-1:0]      second_index,
	input logic [rcp_pkg::CODE_W-1:0]         first_code,
	input logic [rcp_pkg::CODE_W-1:0]         second_code,
	input logic [rcp_pkg::DIST_W-1:0]         dist_sq,
	input logic [rcp_pkg::TOTAL_W-1:0]        contact_count,
	input logic [rcp_pkg::GAP_SUM_W-1:0]      separation_sum
);

	a_busy_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == rcp_pkg::OP_FETCH) |=> in_stall)
		else $error("fetch transfer did not start a scan");

	a_free_after_other: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation != rcp_pkg::OP_FETCH) |=> !in_stall)
		else $error("non-fetch transfer left the input stalled");

	a_end_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !contact_found |-> (first_index == '0) && (second_index == '0)
			&& (first_code == '0) && (second_code == '0) && (dist_sq == '0))
		else $error("end item carries pair fields");

	a_contact_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && contact_found |-> (first_index < second_index)
			&& (contact_count == '0) && (separation_sum == '0))
		else $error("contact item malformed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(contact_found) && $stable(dist_sq))
		else $error("stalled result changed");

endmodule

bind residue_contact_pair_finder rcp_checker u_rcp_checker (.*);
